// ===== hw/rtl/bb3_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the rounding divider of the 3x3 box blur.
// Used by every other file of the block; depends on nothing.
package bb3_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW        = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;
    localparam int ROW_W     = 17;
    localparam int PIX_W     = 24;
    localparam int TAPS      = 9;

    localparam logic [1:0]  REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0]  REG_FRAME_HEIGHT = 2'd1;
    localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [15:0] FRAME_HEIGHT_RST = 16'd480;

    // Reciprocals for the divide by three and nine (exact for 12-bit operands).
    localparam logic [12:0] RECIP3 = 13'd5462;
    localparam logic [12:0] RECIP9 = 13'd7282;

    // One advance of the stream position, decided in the control stage.
    typedef struct packed {
        logic              shift;
        logic              emit;
        logic              pre;
        logic [2:0]        col_ok;
        logic [2:0]        row_ok;
        logic              frame_end;
        logic              restart;
        logic [COL_W-1:0]  col;
        logic [PIX_W-1:0]  px;
    } adv_t;

    // What the merging stage needs about one emitted window.
    typedef struct packed {
        logic [2:0] col_ok;
        logic [2:0] row_ok;
        logic       frame_end;
    } emit_t;

    // y is sum + floor(n/2); the rounded mean is floor(y / n).
    function automatic logic [7:0] div_round(input logic [11:0] y, input logic [3:0] n);
        logic [11:0] a;
        logic [12:0] m;
        logic [24:0] p;
        logic [7:0]  q;
        a = (n == 4'd6) ? {1'b0, y[11:1]} : y;
        m = (n == 4'd9) ? RECIP9 : RECIP3;
        p = a * m;
        case (n)
            4'd2:    q = y[8:1];
            4'd3:    q = p[21:14];
            4'd4:    q = y[9:2];
            4'd6:    q = p[21:14];
            4'd9:    q = p[23:16];
            default: q = y[7:0];
        endcase
        return q;
    endfunction

endpackage

// ===== hw/rtl/box_blur_3x3_edge_normalized.sv =====
`timescale 1ns / 1ps
// Streaming 3x3 box blur of RGB888 pixels, one beat per clock when nothing stalls.
// Each input beat passes the window register, the per-channel sum register and the
// divide into the output register, which holds its result, if any. Two line stores
// share one memory, read and written at most once per cycle. Results lag the input
// by one row and one pixel; after the last pixel, flush beats drain them one per
// beat. On a one-row frame the first flush position is stepped over internally
// before the flush beat is taken. Writing either register restarts the frame.
module box_blur_3x3_edge_normalized (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  pixel_red,
    input  logic [7:0]  pixel_green,
    input  logic [7:0]  pixel_blue,
    input  logic        flush,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  blurred_red,
    output logic [7:0]  blurred_green,
    output logic [7:0]  blurred_blue,
    output logic        frame_end
);

    logic                   a_valid;
    bb3_pkg::adv_t          a_adv;
    logic                   cfg_clear;
    logic                   b_ready;
    logic                   load_c;
    logic [bb3_pkg::TAPS-1:0][bb3_pkg::PIX_W-1:0] taps;
    bb3_pkg::emit_t         b_info;
    logic [bb3_pkg::TAPS-1:0] tap_ok;
    logic [3:0]             n_b;
    logic [2:0][bb3_pkg::TAPS-1:0][7:0] lane_tap;
    logic [2:0][7:0]        lane_q;

    logic                   c_valid_reg;
    logic [3:0]             c_n_reg;
    logic                   c_fe_reg;
    logic                   c_ready;
    logic                   c_go;
    logic                   d_ready;
    logic                   out_valid_reg;
    logic [7:0]             red_reg;
    logic [7:0]             green_reg;
    logic [7:0]             blue_reg;
    logic                   fe_reg;

    bb3_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_red   (pixel_red),
        .pixel_green (pixel_green),
        .pixel_blue  (pixel_blue),
        .flush       (flush),
        .b_ready     (b_ready),
        .a_valid     (a_valid),
        .a_adv       (a_adv),
        .cfg_clear   (cfg_clear)
    );

    bb3_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .a_valid (a_valid),
        .a_adv   (a_adv),
        .clear   (cfg_clear),
        .c_ready (c_ready),
        .b_ready (b_ready),
        .load_c  (load_c),
        .taps    (taps),
        .b_info  (b_info)
    );

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++)
                tap_ok[c*3 + r] = b_info.col_ok[c] & b_info.row_ok[r];
        n_b = 4'($countones(tap_ok));
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < bb3_pkg::TAPS; i++)
                lane_tap[k][i] = taps[i][23 - 8*k -: 8];

        d_ready = !out_valid_reg || !out_stall;
        c_ready = !c_valid_reg || d_ready;
        c_go    = c_valid_reg && d_ready;
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        bb3_lane u_lane (
            .clk    (clk),
            .tap    (lane_tap[k]),
            .tap_ok (tap_ok),
            .n_in   (n_b),
            .load   (load_c),
            .n_div  (c_n_reg),
            .q      (lane_q[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (load_c)
        begin
            c_n_reg  <= n_b;
            c_fe_reg <= b_info.frame_end;
        end
        if (c_go)
        begin
            red_reg   <= lane_q[0];
            green_reg <= lane_q[1];
            blue_reg  <= lane_q[2];
            fe_reg    <= c_fe_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_c)
                c_valid_reg <= 1'b1;
            else if (c_go)
                c_valid_reg <= 1'b0;

            if (c_go)
                out_valid_reg <= 1'b1;
            else if (d_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign blurred_red   = red_reg;
    assign blurred_green = green_reg;
    assign blurred_blue  = blue_reg;
    assign frame_end     = fe_reg;

endmodule

// ===== hw/rtl/bb3_ctrl.sv =====
`timescale 1ns / 1ps
// Configuration registers, stream position counters and input handshake.
// Decides per beat whether the window shifts and which result it gives; uses bb3_pkg.
module bb3_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            pixel_red,
    input  logic [7:0]            pixel_green,
    input  logic [7:0]            pixel_blue,
    input  logic                  flush,
    input  logic                  b_ready,
    output logic                  a_valid,
    output bb3_pkg::adv_t         a_adv,
    output logic                  cfg_clear
);

    logic [11:0]                  frame_width_reg;
    logic [15:0]                  frame_height_reg;
    logic [bb3_pkg::COL_W-1:0]    ic_reg;
    logic [bb3_pkg::ROW_W-1:0]    ir_reg;
    logic [bb3_pkg::COL_W-1:0]    oc_reg;
    logic [15:0]                  or_reg;

    logic [bb3_pkg::EW-1:0]       w;
    logic [bb3_pkg::EW-1:0]       w_raw;
    logic [15:0]                  h;
    logic [bb3_pkg::ROW_W-1:0]    h_ext;
    logic                         past_end;
    logic                         internal;
    logic                         accept;
    logic                         pre;
    logic                         post;
    logic                         emit;
    logic                         fe;
    logic [bb3_pkg::COL_W:0]      oc1;
    logic                         oc_wrap;
    logic [16:0]                  or_n;
    logic [bb3_pkg::COL_W:0]      ic1;
    logic                         ic_wrap;

    always_comb
    begin
        w_raw = bb3_pkg::EW'(frame_width_reg);
        if (frame_width_reg == 12'd0)
            w = bb3_pkg::EW'(1);
        else if (w_raw > bb3_pkg::EW'(bb3_pkg::MAX_WIDTH))
            w = bb3_pkg::EW'(bb3_pkg::MAX_WIDTH);
        else
            w = w_raw;
        h     = (frame_height_reg == 16'd0) ? 16'd1 : frame_height_reg;
        h_ext = bb3_pkg::ROW_W'(h);

        past_end = ir_reg >= h_ext;
        // On a one-row frame the first flush position yields nothing, so it
        // is stepped over internally before the flush beat is taken.
        internal = in_valid && flush && past_end && (ic_reg == '0)
                   && (ir_reg == bb3_pkg::ROW_W'(1));
        in_stall = !b_ready || internal;
        accept   = in_valid && !in_stall;
        a_valid  = (accept && (flush ? past_end : !past_end)) || (b_ready && internal);

        pre  = (ic_reg == '0) && (ir_reg >= bb3_pkg::ROW_W'(2));
        post = (ic_reg != '0) && (ir_reg != '0);
        emit = pre || post;

        oc1     = {1'b0, oc_reg} + 1'b1;
        oc_wrap = bb3_pkg::EW'(oc1) >= w;
        or_n    = oc_wrap ? ({1'b0, or_reg} + 17'd1) : {1'b0, or_reg};
        fe      = emit && (or_n >= {1'b0, h});

        ic1     = {1'b0, ic_reg} + 1'b1;
        ic_wrap = bb3_pkg::EW'(ic1) >= w;

        a_adv.shift     = !(pre && fe);
        a_adv.emit      = emit;
        a_adv.pre       = pre;
        a_adv.frame_end = fe;
        a_adv.restart   = fe;
        a_adv.col       = ic_reg;
        a_adv.px        = flush ? '0 : {pixel_red, pixel_green, pixel_blue};
        if (pre)
        begin
            a_adv.col_ok = {1'b1, (w >= bb3_pkg::EW'(2)), 1'b0};
            a_adv.row_ok = {((ir_reg - 1'b1) < h_ext), 1'b1,
                            (ir_reg >= bb3_pkg::ROW_W'(3))};
        end
        else
        begin
            a_adv.col_ok = {1'b1, 1'b1, (ic_reg >= bb3_pkg::COL_W'(2))};
            a_adv.row_ok = {(ir_reg < h_ext), 1'b1, (ir_reg >= bb3_pkg::ROW_W'(2))};
        end

        cfg_clear = cfg_write && ((cfg_index == bb3_pkg::REG_FRAME_WIDTH)
                                  || (cfg_index == bb3_pkg::REG_FRAME_HEIGHT));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= bb3_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= bb3_pkg::FRAME_HEIGHT_RST;
            ic_reg           <= '0;
            ir_reg           <= '0;
            oc_reg           <= '0;
            or_reg           <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bb3_pkg::REG_FRAME_WIDTH:
                begin
                    frame_width_reg <= cfg_data[11:0];
                    ic_reg <= '0;
                    ir_reg <= '0;
                    oc_reg <= '0;
                    or_reg <= '0;
                end
                bb3_pkg::REG_FRAME_HEIGHT:
                begin
                    frame_height_reg <= cfg_data;
                    ic_reg <= '0;
                    ir_reg <= '0;
                    oc_reg <= '0;
                    or_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (a_valid)
        begin
            if (fe)
            begin
                ic_reg <= '0;
                ir_reg <= '0;
                oc_reg <= '0;
                or_reg <= '0;
            end
            else
            begin
                if (ic_wrap)
                begin
                    ic_reg <= '0;
                    ir_reg <= ir_reg + 1'b1;
                end
                else
                begin
                    ic_reg <= ic1[bb3_pkg::COL_W-1:0];
                end
                if (emit)
                begin
                    oc_reg <= oc_wrap ? '0 : oc1[bb3_pkg::COL_W-1:0];
                    or_reg <= or_n[15:0];
                end
            end
        end
    end

endmodule

// ===== hw/rtl/bb3_window.sv =====
`timescale 1ns / 1ps
// Line store memory and the 3x3 window registers of the box blur.
// Holds one advance per stage slot and feeds the selected window to the lanes; uses bb3_pkg.
module bb3_window (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      a_valid,
    input  bb3_pkg::adv_t                             a_adv,
    input  logic                                      clear,
    input  logic                                      c_ready,
    output logic                                      b_ready,
    output logic                                      load_c,
    output logic [bb3_pkg::TAPS-1:0][bb3_pkg::PIX_W-1:0] taps,
    output bb3_pkg::emit_t                            b_info
);

    // Each word holds the upper row in its high half and the middle row below.
    logic [2*bb3_pkg::PIX_W-1:0]  mem [bb3_pkg::MAX_WIDTH];
    logic [2*bb3_pkg::PIX_W-1:0]  rd_reg;
    logic [2*bb3_pkg::PIX_W-1:0]  wr_data;
    logic                         b_valid_reg;
    bb3_pkg::adv_t                b_adv_reg;
    logic [bb3_pkg::TAPS-1:0][bb3_pkg::PIX_W-1:0] win_reg;
    logic [bb3_pkg::TAPS-1:0][bb3_pkg::PIX_W-1:0] win_shift;
    logic                         b_go;
    logic                         wr_en;

    always_comb
    begin
        b_go    = b_valid_reg && (!b_adv_reg.emit || c_ready);
        b_ready = !b_valid_reg || b_go;
        load_c  = b_go && b_adv_reg.emit;
        wr_en   = b_go && b_adv_reg.shift;
        wr_data = {rd_reg[bb3_pkg::PIX_W-1:0], b_adv_reg.px};

        for (int i = 0; i < 6; i++)
            win_shift[i] = win_reg[i + 3];
        win_shift[6] = rd_reg[2*bb3_pkg::PIX_W-1:bb3_pkg::PIX_W];
        win_shift[7] = rd_reg[bb3_pkg::PIX_W-1:0];
        win_shift[8] = b_adv_reg.px;

        taps             = b_adv_reg.pre ? win_reg : win_shift;
        b_info.col_ok    = b_adv_reg.col_ok;
        b_info.row_ok    = b_adv_reg.row_ok;
        b_info.frame_end = b_adv_reg.frame_end;
    end

    // A write to the column being read in the same cycle is forwarded.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[b_adv_reg.col] <= wr_data;
        if (a_valid)
        begin
            if (wr_en && (b_adv_reg.col == a_adv.col))
                rd_reg <= wr_data;
            else
                rd_reg <= mem[a_adv.col];
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_valid)
            b_adv_reg <= a_adv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            win_reg     <= '0;
        end
        else
        begin
            if (a_valid)
                b_valid_reg <= 1'b1;
            else if (b_go)
                b_valid_reg <= 1'b0;

            if (clear)
                win_reg <= '0;
            else if (b_go)
            begin
                if (b_adv_reg.restart)
                    win_reg <= '0;
                else if (b_adv_reg.shift)
                    win_reg <= win_shift;
            end
        end
    end

endmodule

// ===== hw/rtl/bb3_lane.sv =====
`timescale 1ns / 1ps
// One color channel of the blur: masked nine-tap sum, then the rounding divide.
// Uses bb3_pkg for the divider function.
module bb3_lane (
    input  logic                           clk,
    input  logic [bb3_pkg::TAPS-1:0][7:0]  tap,
    input  logic [bb3_pkg::TAPS-1:0]       tap_ok,
    input  logic [3:0]                     n_in,
    input  logic                           load,
    input  logic [3:0]                     n_div,
    output logic [7:0]                     q
);

    logic [11:0] sum;
    logic [11:0] y;
    logic [11:0] y_reg;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < bb3_pkg::TAPS; i++)
            sum = sum + (tap_ok[i] ? 12'(tap[i]) : 12'd0);
        // Adding half the tap count makes the floor divide round half up.
        y = sum + 12'(n_in[3:1]);
        q = bb3_pkg::div_round(y_reg, n_div);
    end

    always_ff @(posedge clk)
    begin
        if (load)
            y_reg <= y;
    end

endmodule
